@@ design/sapc_pkg.sv @@
`default_nettype none

package sapc_pkg;

    localparam int MAX_TEXT_DEF    = 4096;
    localparam int MAX_PATTERN_DEF = 64;
    localparam int ALPHABET_DEF    = 256;

    localparam int SYM_W   = 8;
    localparam int COUNT_W = 13;

    localparam logic [SYM_W-1:0] SENTINEL_RST = 8'd36;

    // word kinds on the input and output streams
    localparam logic OP_TEXT    = 1'b0;
    localparam logic OP_PATTERN = 1'b1;
    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // symbols at or above the alphabet size saturate to its top symbol
    function automatic logic [SYM_W-1:0] clamp_sym(input logic [SYM_W-1:0] s,
                                                   input int alphabet);
        logic [SYM_W:0] lim;
        lim = (SYM_W+1)'(alphabet);
        if ({1'b0, s} >= lim)
            return SYM_W'(alphabet - 1);
        return s;
    endfunction

endpackage

`default_nettype wire

@@ design/suffix_array_pattern_count.sv @@
`default_nettype none

// Suffix-array pattern counter. Send text symbols (tuser = 0) one word per cycle; on the
// word with tlast the sentinel is appended and the cyclic suffix order of text plus
// sentinel is built by prefix doubling with counting sorts, after which one build word
// (tuser = 0, count 0) is returned. Pattern symbols (tuser = 1) follow, one word per
// cycle; tlast on a pattern starts two binary searches over the order and one count word
// (tuser = 1) is returned. Every pass walks synchronous memories (one read and one write
// port each) one entry at a time; the build of n = text length + 1 entries runs a first
// counting sort on the symbols and then ceil(log2 n) doubling rounds. A query takes up
// to 2*ceil(log2 n) probes, each comparing the pattern with one suffix symbol by symbol.
// Up to MAX_TEXT-1 text and MAX_PATTERN pattern symbols are kept; extra ones are dropped
// and flagged in tdata bit 13. New text after a build discards the old order.

module suffix_array_pattern_count #(
    parameter int MAX_TEXT    = sapc_pkg::MAX_TEXT_DEF,
    parameter int MAX_PATTERN = sapc_pkg::MAX_PATTERN_DEF,
    parameter int ALPHABET    = sapc_pkg::ALPHABET_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [12:0] match_count, [13] overflow, rest zero
    output logic        m_axis_tuser,   // [0] result_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data        // sentinel_symbol
);

    localparam int IW  = sapc_pkg::addr_w(MAX_TEXT);
    localparam int CW  = $clog2(MAX_TEXT + 1);
    localparam int PAW = sapc_pkg::addr_w(MAX_PATTERN);
    localparam int PLW = $clog2(MAX_PATTERN + 1);
    localparam int SW  = sapc_pkg::SYM_W;

    typedef enum logic [5:0] {
        T_IDLE   = 6'b000001,
        T_SENT   = 6'b000010,
        T_BUILD  = 6'b000100,
        T_QSTART = 6'b001000,
        T_QUERY  = 6'b010000,
        T_EMIT   = 6'b100000
    } top_state_t;

    top_state_t state_reg;

    logic [SW-1:0]  sentinel_reg;
    logic [IW-1:0]  tl_reg;
    logic           text_ovf_reg;
    logic [CW-1:0]  order_n_reg;
    logic [PLW-1:0] plen_reg;
    logic           pat_ovf_reg;
    logic           res_kind_reg;
    logic           res_ovf_reg;
    logic [sapc_pkg::COUNT_W-1:0] res_cnt_reg;
    logic           out_valid_reg;
    logic [15:0]    out_data_reg;
    logic           out_kind_reg;

    logic           accept;
    logic           is_text;
    logic           text_room;
    logic           pat_room;
    logic [SW-1:0]  sym_c;
    logic [CW-1:0]  build_n;
    logic           emit_go;

    logic           text_we;
    logic [SW-1:0]  text_wdata;
    logic [IW-1:0]  text_raddr;
    logic [SW-1:0]  text_rdata;
    logic [IW-1:0]  sa_raddr;
    logic [IW-1:0]  sa_rdata;
    logic           pat_we;
    logic [PAW-1:0] pat_raddr;
    logic [SW-1:0]  pat_rdata;

    logic           b_done;
    logic [IW-1:0]  b_taddr, b_saddr;
    logic           b_sa_we;
    logic [IW-1:0]  b_sa_waddr, b_sa_wdata;

    logic           s_done;
    logic [sapc_pkg::COUNT_W-1:0] s_count;
    logic [IW-1:0]  s_taddr, s_saddr;

    assign s_axis_tready = (state_reg == T_IDLE);
    assign cfg_ready     = 1'b1;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_text       = (s_axis_tuser == sapc_pkg::OP_TEXT);
    assign text_room     = (CW'(tl_reg) < CW'(MAX_TEXT - 1));
    assign pat_room      = (plen_reg < PLW'(MAX_PATTERN));
    assign sym_c         = sapc_pkg::clamp_sym(s_axis_tdata, ALPHABET);
    assign build_n       = CW'(tl_reg) + CW'(1);
    assign emit_go       = (state_reg == T_EMIT) && (!out_valid_reg || m_axis_tready);

    // sentinel goes in the cycle after the closing text word
    assign text_we    = (accept && is_text && text_room) || (state_reg == T_SENT);
    assign text_wdata = (state_reg == T_SENT) ?
                        sapc_pkg::clamp_sym(sentinel_reg, ALPHABET) : sym_c;
    assign pat_we     = accept && !is_text && pat_room;

    assign text_raddr = (state_reg == T_BUILD) ? b_taddr : s_taddr;
    assign sa_raddr   = (state_reg == T_BUILD) ? b_saddr : s_saddr;

    sapc_ram #(.WIDTH(SW), .DEPTH(MAX_TEXT)) u_text (
        .clk(clk), .we(text_we), .waddr(tl_reg), .wdata(text_wdata),
        .raddr(text_raddr), .rdata(text_rdata)
    );

    sapc_ram #(.WIDTH(IW), .DEPTH(MAX_TEXT)) u_sa (
        .clk(clk), .we(b_sa_we), .waddr(b_sa_waddr), .wdata(b_sa_wdata),
        .raddr(sa_raddr), .rdata(sa_rdata)
    );

    sapc_ram #(.WIDTH(SW), .DEPTH(MAX_PATTERN)) u_pat (
        .clk(clk), .we(pat_we), .waddr(plen_reg[PAW-1:0]), .wdata(sym_c),
        .raddr(pat_raddr), .rdata(pat_rdata)
    );

    sapc_build #(.MAX_TEXT(MAX_TEXT), .ALPHABET(ALPHABET)) u_build (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (state_reg == T_SENT),
        .n          (build_n),
        .done       (b_done),
        .text_raddr (b_taddr),
        .text_rdata (text_rdata),
        .sa_raddr   (b_saddr),
        .sa_rdata   (sa_rdata),
        .sa_we      (b_sa_we),
        .sa_waddr   (b_sa_waddr),
        .sa_wdata   (b_sa_wdata)
    );

    sapc_search #(.MAX_TEXT(MAX_TEXT), .MAX_PATTERN(MAX_PATTERN)) u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (state_reg == T_QSTART),
        .n          (order_n_reg),
        .plen       (plen_reg),
        .done       (s_done),
        .count      (s_count),
        .text_raddr (s_taddr),
        .text_rdata (text_rdata),
        .sa_raddr   (s_saddr),
        .sa_rdata   (sa_rdata),
        .pat_raddr  (pat_raddr),
        .pat_rdata  (pat_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            sentinel_reg  <= sapc_pkg::SENTINEL_RST;
            tl_reg        <= '0;
            text_ovf_reg  <= 1'b0;
            order_n_reg   <= '0;
            plen_reg      <= '0;
            pat_ovf_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                sentinel_reg <= cfg_data;
            end
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        if (is_text)
                        begin
                            order_n_reg <= '0;
                            if (text_room)
                                tl_reg <= tl_reg + 1'b1;
                            else
                                text_ovf_reg <= 1'b1;
                            if (s_axis_tlast)
                                state_reg <= T_SENT;
                        end
                        else
                        begin
                            if (pat_room)
                                plen_reg <= plen_reg + 1'b1;
                            else
                                pat_ovf_reg <= 1'b1;
                            if (s_axis_tlast)
                                state_reg <= T_QSTART;
                        end
                    end
                end
                T_SENT:
                begin
                    order_n_reg  <= build_n;
                    tl_reg       <= '0;
                    text_ovf_reg <= 1'b0;
                    state_reg    <= T_BUILD;
                end
                T_BUILD:
                begin
                    if (b_done)
                        state_reg <= T_EMIT;
                end
                T_QSTART: state_reg <= T_QUERY;
                T_QUERY:
                begin
                    if (s_done)
                    begin
                        plen_reg    <= '0;
                        pat_ovf_reg <= 1'b0;
                        state_reg   <= T_EMIT;
                    end
                end
                T_EMIT:
                begin
                    if (emit_go)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == T_SENT)
        begin
            res_kind_reg <= sapc_pkg::KIND_BUILD;
            res_ovf_reg  <= text_ovf_reg;
            res_cnt_reg  <= '0;
        end
        if (state_reg == T_QUERY && s_done)
        begin
            res_kind_reg <= sapc_pkg::KIND_COUNT;
            res_ovf_reg  <= pat_ovf_reg;
            res_cnt_reg  <= s_count;
        end
        if (emit_go)
        begin
            out_data_reg <= {2'b00, res_ovf_reg, res_cnt_reg};
            out_kind_reg <= res_kind_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

endmodule

`default_nettype wire

@@ design/sapc_ram.sv @@
`default_nettype none

module sapc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = sapc_pkg::addr_w(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/sapc_build.sv @@
`default_nettype none

module sapc_build #(
    parameter int MAX_TEXT = sapc_pkg::MAX_TEXT_DEF,
    parameter int ALPHABET = sapc_pkg::ALPHABET_DEF,
    localparam int IW = sapc_pkg::addr_w(MAX_TEXT),
    localparam int CW = $clog2(MAX_TEXT + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [CW-1:0]              n,
    output logic                       done,
    output logic [IW-1:0]              text_raddr,
    input  logic [sapc_pkg::SYM_W-1:0] text_rdata,
    output logic [IW-1:0]              sa_raddr,
    input  logic [IW-1:0]              sa_rdata,
    output logic                       sa_we,
    output logic [IW-1:0]              sa_waddr,
    output logic [IW-1:0]              sa_wdata
);

    localparam int BUCKETS = (ALPHABET > MAX_TEXT) ? ALPHABET : MAX_TEXT;
    localparam int BW      = sapc_pkg::addr_w(BUCKETS);

    typedef enum logic [30:0] {
        ST_IDLE  = 31'd1 << 0,
        ST_CLR   = 31'd1 << 1,
        ST_H_RT  = 31'd1 << 2,
        ST_H_RB  = 31'd1 << 3,
        ST_H_WB  = 31'd1 << 4,
        ST_PS_R  = 31'd1 << 5,
        ST_PS_W  = 31'd1 << 6,
        ST_SC_RT = 31'd1 << 7,
        ST_SC_RB = 31'd1 << 8,
        ST_SC_W  = 31'd1 << 9,
        ST_CI_RS = 31'd1 << 10,
        ST_CI_RT = 31'd1 << 11,
        ST_CI_W  = 31'd1 << 12,
        ST_DS_R  = 31'd1 << 13,
        ST_DS_W  = 31'd1 << 14,
        ST_DH_RS = 31'd1 << 15,
        ST_DH_RC = 31'd1 << 16,
        ST_DH_RB = 31'd1 << 17,
        ST_DH_W  = 31'd1 << 18,
        ST_DT_RS = 31'd1 << 19,
        ST_DT_RC = 31'd1 << 20,
        ST_DT_RB = 31'd1 << 21,
        ST_DT_W  = 31'd1 << 22,
        ST_NC_RS = 31'd1 << 23,
        ST_NC_RA = 31'd1 << 24,
        ST_NC_RM = 31'd1 << 25,
        ST_NC_W  = 31'd1 << 26,
        ST_CP_R  = 31'd1 << 27,
        ST_CP_W  = 31'd1 << 28,
        ST_CHK   = 31'd1 << 29,
        ST_DONE  = 31'd1 << 30
    } build_state_t;

    build_state_t state_reg;

    logic [CW-1:0] n_reg;
    logic [CW-1:0] i_reg;
    logic [BW-1:0] j_reg;
    logic [BW-1:0] lim_reg;
    logic [IW-1:0] cls_reg;
    logic [CW-1:0] sh_reg;
    logic [CW-1:0] sum_reg;
    logic          dbl_reg;

    logic [IW-1:0]              a_reg;
    logic [IW-1:0]              p_reg;
    logic [BW-1:0]              k_reg;
    logic [IW-1:0]              ca_reg;
    logic [sapc_pkg::SYM_W-1:0] prev_sym_reg;
    logic [IW-1:0]              prev_a_reg;
    logic [IW-1:0]              prev_m_reg;

    logic          c_we, cn_we, shf_we, bkt_we;
    logic [IW-1:0] c_waddr, c_wdata, c_raddr, c_rdata;
    logic [IW-1:0] cn_waddr, cn_wdata, cn_raddr, cn_rdata;
    logic [IW-1:0] shf_wdata, shf_raddr, shf_rdata;
    logic [BW-1:0] bkt_waddr, bkt_raddr;
    logic [CW-1:0] bkt_wdata, bkt_rdata;

    logic          last_i;
    logic          chg;
    logic [IW-1:0] cls_new;
    logic [CW-1:0] sum_new;
    logic [CW-1:0] bkt_dec;
    logic [CW:0]   sh_ext, n_ext, p_ext, shv, ma_sum, ma_ext;

    sapc_ram #(.WIDTH(IW), .DEPTH(MAX_TEXT)) u_cls (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    sapc_ram #(.WIDTH(IW), .DEPTH(MAX_TEXT)) u_ncls (
        .clk(clk), .we(cn_we), .waddr(cn_waddr), .wdata(cn_wdata),
        .raddr(cn_raddr), .rdata(cn_rdata)
    );

    sapc_ram #(.WIDTH(IW), .DEPTH(MAX_TEXT)) u_shf (
        .clk(clk), .we(shf_we), .waddr(i_reg[IW-1:0]), .wdata(shf_wdata),
        .raddr(shf_raddr), .rdata(shf_rdata)
    );

    sapc_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_bkt (
        .clk(clk), .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
        .raddr(bkt_raddr), .rdata(bkt_rdata)
    );

    assign last_i  = (i_reg == n_reg - CW'(1));
    assign sum_new = sum_reg + bkt_rdata;
    assign bkt_dec = bkt_rdata - CW'(1);

    assign sh_ext = (CW+1)'(sh_reg);
    assign n_ext  = (CW+1)'(n_reg);
    assign p_ext  = (CW+1)'(sa_rdata);
    assign shv    = (p_ext >= sh_ext) ? p_ext - sh_ext : p_ext + n_ext - sh_ext;
    // partner suffix one shift further on, wrapped round the text
    assign ma_sum = (CW+1)'(a_reg) + sh_ext;
    assign ma_ext = (ma_sum >= n_ext) ? ma_sum - n_ext : ma_sum;

    always_comb
    begin
        if (state_reg == ST_CI_W)
            chg = (text_rdata != prev_sym_reg);
        else
            chg = (ca_reg != prev_a_reg) || (c_rdata != prev_m_reg);
        if (i_reg == '0)
            cls_new = '0;
        else if (chg)
            cls_new = cls_reg + 1'b1;
        else
            cls_new = cls_reg;
    end

    always_comb
    begin
        text_raddr = i_reg[IW-1:0];
        sa_raddr   = i_reg[IW-1:0];
        shf_raddr  = i_reg[IW-1:0];
        cn_raddr   = i_reg[IW-1:0];
        c_raddr    = shf_rdata;
        bkt_raddr  = j_reg;
        bkt_we     = 1'b0;
        bkt_waddr  = k_reg;
        bkt_wdata  = bkt_rdata + CW'(1);
        sa_we      = 1'b0;
        sa_waddr   = IW'(bkt_dec);
        sa_wdata   = i_reg[IW-1:0];
        shf_we     = 1'b0;
        shf_wdata  = IW'(shv);
        c_we       = 1'b0;
        c_waddr    = a_reg;
        c_wdata    = cls_new;
        cn_we      = 1'b0;
        cn_waddr   = a_reg;
        cn_wdata   = cls_new;
        case (state_reg)
            ST_H_RB, ST_SC_RB:
            begin
                bkt_raddr = BW'(text_rdata);
            end
            ST_H_WB, ST_DH_W:
            begin
                bkt_we = 1'b1;
            end
            ST_PS_W:
            begin
                bkt_we    = 1'b1;
                bkt_waddr = j_reg;
                bkt_wdata = sum_new;
            end
            ST_CLR:
            begin
                bkt_we    = 1'b1;
                bkt_waddr = j_reg;
                bkt_wdata = '0;
            end
            ST_SC_W:
            begin
                bkt_we    = 1'b1;
                bkt_wdata = bkt_dec;
                sa_we     = 1'b1;
            end
            ST_DT_W:
            begin
                bkt_we    = 1'b1;
                bkt_wdata = bkt_dec;
                sa_we     = 1'b1;
                sa_wdata  = p_reg;
            end
            ST_CI_RT:
            begin
                text_raddr = sa_rdata;
            end
            ST_CI_W:
            begin
                c_we = 1'b1;
            end
            ST_DS_W:
            begin
                shf_we = 1'b1;
            end
            ST_DH_RB, ST_DT_RB:
            begin
                bkt_raddr = BW'(c_rdata);
            end
            ST_NC_RA:
            begin
                c_raddr = sa_rdata;
            end
            ST_NC_RM:
            begin
                c_raddr = IW'(ma_ext);
            end
            ST_NC_W:
            begin
                cn_we = 1'b1;
            end
            ST_CP_W:
            begin
                c_we    = 1'b1;
                c_waddr = i_reg[IW-1:0];
                c_wdata = cn_rdata;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            lim_reg   <= '0;
            cls_reg   <= '0;
            sh_reg    <= '0;
            sum_reg   <= '0;
            dbl_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        n_reg     <= n;
                        j_reg     <= '0;
                        lim_reg   <= BW'(ALPHABET - 1);
                        dbl_reg   <= 1'b0;
                        state_reg <= ST_CLR;
                    end
                end
                ST_CLR:
                begin
                    if (j_reg == lim_reg)
                    begin
                        i_reg     <= '0;
                        state_reg <= dbl_reg ? ST_DH_RS : ST_H_RT;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_H_RT: state_reg <= ST_H_RB;
                ST_H_RB: state_reg <= ST_H_WB;
                ST_H_WB:
                begin
                    if (last_i)
                    begin
                        j_reg     <= '0;
                        sum_reg   <= '0;
                        state_reg <= ST_PS_R;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_H_RT;
                    end
                end
                ST_PS_R: state_reg <= ST_PS_W;
                ST_PS_W:
                begin
                    sum_reg <= sum_new;
                    if (j_reg == lim_reg)
                    begin
                        i_reg     <= dbl_reg ? n_reg - CW'(1) : '0;
                        state_reg <= dbl_reg ? ST_DT_RS : ST_SC_RT;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_PS_R;
                    end
                end
                ST_SC_RT: state_reg <= ST_SC_RB;
                ST_SC_RB: state_reg <= ST_SC_W;
                ST_SC_W:
                begin
                    if (last_i)
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_CI_RS;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_SC_RT;
                    end
                end
                ST_CI_RS: state_reg <= ST_CI_RT;
                ST_CI_RT: state_reg <= ST_CI_W;
                ST_CI_W:
                begin
                    cls_reg <= cls_new;
                    if (last_i)
                    begin
                        sh_reg    <= CW'(1);
                        i_reg     <= '0;
                        state_reg <= ST_DS_R;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_CI_RS;
                    end
                end
                ST_DS_R: state_reg <= ST_DS_W;
                ST_DS_W:
                begin
                    if (last_i)
                    begin
                        j_reg     <= '0;
                        lim_reg   <= BW'(cls_reg);
                        dbl_reg   <= 1'b1;
                        state_reg <= ST_CLR;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_DS_R;
                    end
                end
                ST_DH_RS: state_reg <= ST_DH_RC;
                ST_DH_RC: state_reg <= ST_DH_RB;
                ST_DH_RB: state_reg <= ST_DH_W;
                ST_DH_W:
                begin
                    if (last_i)
                    begin
                        j_reg     <= '0;
                        sum_reg   <= '0;
                        state_reg <= ST_PS_R;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_DH_RS;
                    end
                end
                ST_DT_RS: state_reg <= ST_DT_RC;
                ST_DT_RC: state_reg <= ST_DT_RB;
                ST_DT_RB: state_reg <= ST_DT_W;
                ST_DT_W:
                begin
                    // scatter runs from the top down to keep the sort stable
                    if (i_reg == '0)
                    begin
                        state_reg <= ST_NC_RS;
                    end
                    else
                    begin
                        i_reg     <= i_reg - 1'b1;
                        state_reg <= ST_DT_RS;
                    end
                end
                ST_NC_RS: state_reg <= ST_NC_RA;
                ST_NC_RA: state_reg <= ST_NC_RM;
                ST_NC_RM: state_reg <= ST_NC_W;
                ST_NC_W:
                begin
                    cls_reg <= cls_new;
                    if (last_i)
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_CP_R;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_NC_RS;
                    end
                end
                ST_CP_R: state_reg <= ST_CP_W;
                ST_CP_W:
                begin
                    if (last_i)
                    begin
                        state_reg <= ST_CHK;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_CP_R;
                    end
                end
                ST_CHK:
                begin
                    if ((sh_ext << 1) >= n_ext)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        sh_reg    <= sh_reg << 1;
                        i_reg     <= '0;
                        state_reg <= ST_DS_R;
                    end
                end
                ST_DONE: state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_H_RB, ST_SC_RB, ST_DH_RB, ST_DT_RB:
            begin
                k_reg <= bkt_raddr;
            end
            ST_CI_RT, ST_NC_RA:
            begin
                a_reg <= sa_rdata;
            end
            ST_CI_W:
            begin
                prev_sym_reg <= text_rdata;
            end
            ST_DT_RC:
            begin
                p_reg <= shf_rdata;
            end
            ST_NC_RM:
            begin
                ca_reg <= c_rdata;
            end
            ST_NC_W:
            begin
                prev_a_reg <= ca_reg;
                prev_m_reg <= c_rdata;
            end
            default:
            begin
            end
        endcase
    end

    assign done = (state_reg == ST_DONE);

endmodule

`default_nettype wire

@@ design/sapc_search.sv @@
`default_nettype none

module sapc_search #(
    parameter int MAX_TEXT    = sapc_pkg::MAX_TEXT_DEF,
    parameter int MAX_PATTERN = sapc_pkg::MAX_PATTERN_DEF,
    localparam int IW  = sapc_pkg::addr_w(MAX_TEXT),
    localparam int CW  = $clog2(MAX_TEXT + 1),
    localparam int PAW = sapc_pkg::addr_w(MAX_PATTERN),
    localparam int PLW = $clog2(MAX_PATTERN + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [CW-1:0]                n,
    input  logic [PLW-1:0]               plen,
    output logic                         done,
    output logic [sapc_pkg::COUNT_W-1:0] count,
    output logic [IW-1:0]                text_raddr,
    input  logic [sapc_pkg::SYM_W-1:0]   text_rdata,
    output logic [IW-1:0]                sa_raddr,
    input  logic [IW-1:0]                sa_rdata,
    output logic [PAW-1:0]               pat_raddr,
    input  logic [sapc_pkg::SYM_W-1:0]   pat_rdata
);

    localparam int KW = (CW > PLW) ? CW : PLW;

    typedef enum logic [5:0] {
        SS_IDLE = 6'b000001,
        SS_SR   = 6'b000010,
        SS_SP   = 6'b000100,
        SS_CR   = 6'b001000,
        SS_CC   = 6'b010000,
        SS_DONE = 6'b100000
    } search_state_t;

    search_state_t state_reg;

    logic [CW-1:0]  n_reg;
    logic [PLW-1:0] plen_reg;
    logic [CW-1:0]  l_reg, r_reg, lo_reg, m_reg;
    logic           upper_reg;
    logic [IW-1:0]  pos_reg;
    logic [PLW-1:0] k_reg, ci_reg;
    logic [sapc_pkg::COUNT_W-1:0] count_reg;

    logic [CW:0]    m_ext;
    logic [CW-1:0]  m;
    logic [CW-1:0]  rem;
    logic [PLW-1:0] k_new;
    logic           dec_valid, dec_lt, dec_eq, move_l;

    assign m_ext = ((CW+1)'(l_reg) + (CW+1)'(r_reg)) >> 1;
    assign m     = CW'(m_ext);
    assign rem   = n_reg - CW'(sa_rdata);
    assign k_new = (KW'(rem) < KW'(plen_reg)) ? PLW'(rem) : plen_reg;

    assign sa_raddr   = m[IW-1:0];
    assign text_raddr = IW'(CW'(pos_reg) + CW'(ci_reg));
    assign pat_raddr  = ci_reg[PAW-1:0];

    // outcome of one suffix compare; a cut suffix that matched so far is smaller
    always_comb
    begin
        dec_valid = 1'b0;
        dec_lt    = 1'b0;
        dec_eq    = 1'b0;
        if (state_reg == SS_CR && ci_reg == k_reg)
        begin
            dec_valid = 1'b1;
            dec_lt    = (k_reg < plen_reg);
            dec_eq    = !(k_reg < plen_reg);
        end
        else if (state_reg == SS_CC && text_rdata != pat_rdata)
        begin
            dec_valid = 1'b1;
            dec_lt    = (text_rdata < pat_rdata);
        end
        move_l = dec_lt || (upper_reg && dec_eq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SS_IDLE;
            n_reg     <= '0;
            plen_reg  <= '0;
            l_reg     <= '0;
            r_reg     <= '0;
            lo_reg    <= '0;
            m_reg     <= '0;
            upper_reg <= 1'b0;
            k_reg     <= '0;
            ci_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            case (state_reg)
                SS_IDLE:
                begin
                    if (start)
                    begin
                        n_reg     <= n;
                        plen_reg  <= plen;
                        l_reg     <= '0;
                        r_reg     <= n;
                        upper_reg <= 1'b0;
                        if (n == '0 || KW'(plen) >= KW'(n))
                        begin
                            count_reg <= '0;
                            state_reg <= SS_DONE;
                        end
                        else
                        begin
                            state_reg <= SS_SR;
                        end
                    end
                end
                SS_SR:
                begin
                    if (r_reg - l_reg > CW'(1))
                    begin
                        m_reg     <= m;
                        state_reg <= SS_SP;
                    end
                    else if (!upper_reg)
                    begin
                        lo_reg    <= l_reg;
                        l_reg     <= '0;
                        r_reg     <= n_reg;
                        upper_reg <= 1'b1;
                    end
                    else
                    begin
                        count_reg <= (l_reg > lo_reg) ?
                                     sapc_pkg::COUNT_W'(l_reg - lo_reg) : '0;
                        state_reg <= SS_DONE;
                    end
                end
                SS_SP:
                begin
                    k_reg     <= k_new;
                    ci_reg    <= '0;
                    state_reg <= SS_CR;
                end
                SS_CR:
                begin
                    if (!dec_valid)
                    begin
                        state_reg <= SS_CC;
                    end
                end
                SS_CC:
                begin
                    if (!dec_valid)
                    begin
                        ci_reg    <= ci_reg + 1'b1;
                        state_reg <= SS_CR;
                    end
                end
                SS_DONE: state_reg <= SS_IDLE;
                default: state_reg <= SS_IDLE;
            endcase
            if (dec_valid)
            begin
                if (move_l)
                    l_reg <= m_reg;
                else
                    r_reg <= m_reg;
                state_reg <= SS_SR;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == SS_SP)
        begin
            pos_reg <= sa_rdata;
        end
    end

    assign done  = (state_reg == SS_DONE);
    assign count = count_reg;

endmodule

`default_nettype wire

@@ bench/suffix_array_pattern_count_tb.sv @@
`default_nettype none

module suffix_array_pattern_count_tb;

    localparam int TXT_MAX = sapc_pkg::MAX_TEXT_DEF;
    localparam int PAT_MAX = sapc_pkg::MAX_PATTERN_DEF;
    localparam int N_ITEMS = 1950;

    typedef struct {
        logic                         kind;
        logic [sapc_pkg::COUNT_W-1:0] count;
        logic                         ovf;
    } outcome_t;

    typedef struct packed {
        logic                         op;
        logic [sapc_pkg::SYM_W-1:0]   sym;
        logic                         last;
        logic                         fixed;
        logic [sapc_pkg::COUNT_W-1:0] count;
        logic                         ovf;
    } step_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    suffix_array_pattern_count u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] symbol
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),   // [0] opcode
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [12:0] match_count, [13] overflow
        .m_axis_tuser  (m_axis_tuser),   // [0] result_kind
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0; #2;
        clk = 1'b1; #2;
    end

    // predictor state
    int txt [TXT_MAX];
    int sfx [TXT_MAX];
    int cls [TXT_MAX];
    int ncls [TXT_MAX];
    int shf [TXT_MAX];
    int bkt [TXT_MAX];
    int pat [PAT_MAX];
    int txt_len, pat_len, order_n;
    bit txt_ovf, pat_ovf;
    logic [7:0] sentinel;

    outcome_t expected_q[$];
    int errors, words_in, words_out, builds, counts, hits;
    int cyc;
    bit calm;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch on word %0d: %s got %0d expected %0d", words_out, what, got, want);
        errors++;
    endtask

    function automatic void build_order(input int n);
        int i, classes, sh, p, a, b, ma, mb;
        for (i = 0; i < TXT_MAX; i++) bkt[i] = 0;
        for (i = 0; i < n; i++) bkt[txt[i]]++;
        for (i = 1; i < sapc_pkg::ALPHABET_DEF; i++) bkt[i] += bkt[i-1];
        for (i = 0; i < n; i++)
        begin
            bkt[txt[i]]--;
            sfx[bkt[txt[i]]] = i;
        end
        cls[sfx[0]] = 0;
        classes = 1;
        for (i = 1; i < n; i++)
        begin
            if (txt[sfx[i]] != txt[sfx[i-1]]) classes++;
            cls[sfx[i]] = classes - 1;
        end
        for (sh = 1; sh < n; sh = sh << 1)
        begin
            for (i = 0; i < n; i++)
            begin
                p = sfx[i];
                shf[i] = (p >= sh) ? p - sh : p + n - sh;
            end
            for (i = 0; i < classes; i++) bkt[i] = 0;
            for (i = 0; i < n; i++) bkt[cls[shf[i]]]++;
            for (i = 1; i < classes; i++) bkt[i] += bkt[i-1];
            for (i = n - 1; i >= 0; i--)
            begin
                bkt[cls[shf[i]]]--;
                sfx[bkt[cls[shf[i]]]] = shf[i];
            end
            ncls[sfx[0]] = 0;
            classes = 1;
            for (i = 1; i < n; i++)
            begin
                a = sfx[i];
                b = sfx[i-1];
                ma = a + sh;
                mb = b + sh;
                if (ma >= n) ma -= n;
                if (mb >= n) mb -= n;
                if (cls[a] != cls[b] || cls[ma] != cls[mb]) classes++;
                ncls[a] = classes - 1;
            end
            for (i = 0; i < n; i++) cls[i] = ncls[i];
            if (sh > (n >> 1)) break;
        end
    endfunction

    function automatic int compare_at(input int pos);
        int k, i;
        k = order_n - pos;
        if (k > pat_len) k = pat_len;
        for (i = 0; i < k; i++)
            if (txt[pos+i] != pat[i])
                return (txt[pos+i] < pat[i]) ? -1 : 1;
        return (k < pat_len) ? -1 : 0;
    endfunction

    function automatic int occurrences();
        int l, r, m, lo;
        if (order_n == 0 || pat_len >= order_n) return 0;
        l = 0; r = order_n;
        while (r - l > 1)
        begin
            m = l + (r - l) / 2;
            if (compare_at(sfx[m]) < 0) l = m; else r = m;
        end
        lo = l;
        l = 0; r = order_n;
        while (r - l > 1)
        begin
            m = l + (r - l) / 2;
            if (compare_at(sfx[m]) <= 0) l = m; else r = m;
        end
        return (l > lo) ? l - lo : 0;
    endfunction

    // returns 1 when the word yields a result
    function automatic bit predict_word(input logic op, input logic [7:0] sym,
                                        input logic last, output outcome_t res);
        if (op == sapc_pkg::OP_TEXT)
        begin
            if (order_n != 0)
            begin
                order_n = 0;
                txt_len = 0;
                txt_ovf = 0;
            end
            if (txt_len < TXT_MAX - 1) txt[txt_len++] = sym;
            else txt_ovf = 1;
            if (!last) return 0;
            txt[txt_len] = sentinel;
            order_n = txt_len + 1;
            build_order(order_n);
            res.kind = sapc_pkg::KIND_BUILD;
            res.count = '0;
            res.ovf = txt_ovf;
            txt_len = 0;
            txt_ovf = 0;
            return 1;
        end
        if (pat_len < PAT_MAX) pat[pat_len++] = sym;
        else pat_ovf = 1;
        if (!last) return 0;
        res.kind = sapc_pkg::KIND_COUNT;
        res.count = sapc_pkg::COUNT_W'(occurrences());
        res.ovf = pat_ovf;
        pat_len = 0;
        pat_ovf = 0;
        return 1;
    endfunction

    // idle stretches: no gaps in the first quarter of each period of the cycle count
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        calm <= (cyc % 4000) < 1000;
        m_axis_tready <= calm || ($urandom_range(99) >= 6);
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            words_out++;
            if (expected_q.size() == 0)
            begin
                report("result with none pending", 1, 0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (m_axis_tuser !== want.kind) report("kind", m_axis_tuser, want.kind);
                if (m_axis_tdata[12:0] !== want.count)
                    report("count", m_axis_tdata[12:0], want.count);
                if (m_axis_tdata[13] !== want.ovf) report("overflow", m_axis_tdata[13], want.ovf);
                if (m_axis_tdata[15:14] !== 2'b00) report("pad", m_axis_tdata[15:14], 0);
            end
        end
    end

    task automatic send_word(input logic op, input logic [7:0] sym, input logic last,
                             input bit fixed = 0, input outcome_t fixed_res = '{0, 0, 0});
        outcome_t res;
        while (!calm && $urandom_range(99) < 6)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= sym;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        words_in++;
        if (predict_word(op, sym, last, res))
        begin
            if (fixed) res = fixed_res;
            if (res.kind == sapc_pkg::KIND_BUILD) builds++;
            else
            begin
                counts++;
                if (res.count != 0) hits++;
            end
            expected_q.insert(expected_q.size(), res);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    task automatic set_sentinel(input logic [7:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sentinel = v;
    endtask

    step_t steps[] = '{
        '{sapc_pkg::OP_PATTERN, 8'h61, 1'b1, 1'b1, 13'd0, 1'b0},  // query with no order
        '{sapc_pkg::OP_TEXT,    8'h00, 1'b0, 1'b0, 13'd0, 1'b0},
        '{sapc_pkg::OP_TEXT,    8'hff, 1'b0, 1'b0, 13'd0, 1'b0},
        '{sapc_pkg::OP_TEXT,    8'h61, 1'b0, 1'b0, 13'd0, 1'b0},
        '{sapc_pkg::OP_TEXT,    8'h62, 1'b1, 1'b1, 13'd0, 1'b0},
        '{sapc_pkg::OP_PATTERN, 8'h61, 1'b1, 1'b0, 13'd0, 1'b0},
        '{sapc_pkg::OP_PATTERN, 8'hff, 1'b1, 1'b0, 13'd0, 1'b0},
        '{sapc_pkg::OP_PATTERN, 8'h00, 1'b0, 1'b0, 13'd0, 1'b0},
        '{sapc_pkg::OP_PATTERN, 8'hff, 1'b1, 1'b0, 13'd0, 1'b0},
        '{sapc_pkg::OP_PATTERN, 8'h61, 1'b0, 1'b0, 13'd0, 1'b0},  // as long as text+sentinel
        '{sapc_pkg::OP_PATTERN, 8'h61, 1'b0, 1'b0, 13'd0, 1'b0},
        '{sapc_pkg::OP_PATTERN, 8'h61, 1'b0, 1'b0, 13'd0, 1'b0},
        '{sapc_pkg::OP_PATTERN, 8'h61, 1'b0, 1'b0, 13'd0, 1'b0},
        '{sapc_pkg::OP_PATTERN, 8'h61, 1'b1, 1'b1, 13'd0, 1'b0},
        '{sapc_pkg::OP_TEXT,    8'h78, 1'b0, 1'b0, 13'd0, 1'b0},  // new text drops the order
        '{sapc_pkg::OP_PATTERN, 8'h61, 1'b1, 1'b1, 13'd0, 1'b0},
        '{sapc_pkg::OP_TEXT,    8'h78, 1'b1, 1'b1, 13'd0, 1'b0},
        '{sapc_pkg::OP_PATTERN, 8'h78, 1'b1, 1'b0, 13'd0, 1'b0}
    };

    initial
    begin
        #40000000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int i, j, n, np, len, start, base;
        int txt_copy[$];
        outcome_t fx;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        cyc = 0;
        calm = 1'b1;
        errors = 0; words_in = 0; words_out = 0; builds = 0; counts = 0; hits = 0;
        sentinel = sapc_pkg::SENTINEL_RST;
        txt_len = 0; pat_len = 0; order_n = 0; txt_ovf = 0; pat_ovf = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[k])
        begin
            fx.kind = steps[k].op;
            fx.count = steps[k].count;
            fx.ovf = steps[k].ovf;
            send_word(steps[k].op, steps[k].sym, steps[k].last, steps[k].fixed, fx);
        end
        // pattern beyond its store
        for (i = 0; i < PAT_MAX + 6; i++)
            send_word(sapc_pkg::OP_PATTERN, 8'h78, i == PAT_MAX + 5);

        // text beyond its store, smallest sentinel; the last two symbols are dropped
        set_sentinel(8'h00);
        for (i = 0; i < TXT_MAX + 1; i++)
            send_word(sapc_pkg::OP_TEXT, 8'($urandom_range(1, 3)), i == TXT_MAX);
        for (i = 0; i < 6; i++)
        begin
            n = $urandom_range(1, 5);
            for (j = 0; j < n; j++)
                send_word(sapc_pkg::OP_PATTERN, 8'($urandom_range(1, 3)), j == n - 1);
        end

        // sentinel above every text symbol
        set_sentinel(8'hff);
        for (i = 0; i < 9; i++)
            send_word(sapc_pkg::OP_TEXT, (i % 3 == 0) ? 8'h62 : 8'h61, i == 8);
        for (i = 0; i < 6; i++)
        begin
            n = $urandom_range(1, 3);
            for (j = 0; j < n; j++)
                send_word(sapc_pkg::OP_PATTERN, (j == 1) ? 8'hff : 8'h61, j == n - 1);
        end

        while (words_in < N_ITEMS + TXT_MAX + 150)
        begin
            if ($urandom_range(3) == 0) set_sentinel(8'($urandom));
            base = $urandom_range(0, 252);
            len = ($urandom_range(39) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
            txt_copy.delete();
            for (i = 0; i < len; i++)
            begin
                j = ($urandom_range(9) == 0) ? $urandom_range(0, 255) : base + $urandom_range(0, 3);
                txt_copy.insert(txt_copy.size(), j);
                // occasionally a query cuts into a loading text
                if ($urandom_range(99) == 0 && i != len - 1)
                    send_word(sapc_pkg::OP_PATTERN, 8'(base), 1'b1);
                send_word(sapc_pkg::OP_TEXT, 8'(j), i == len - 1);
            end
            np = $urandom_range(3, 10);
            for (i = 0; i < np; i++)
            begin
                j = $urandom_range(9);
                if (j < 6)
                begin
                    start = $urandom_range(0, len - 1);
                    n = $urandom_range(1, len - start);
                    for (int k = 0; k < n; k++)
                        send_word(sapc_pkg::OP_PATTERN, 8'(txt_copy[start+k]), k == n - 1);
                end
                else if (j < 9)
                begin
                    n = (j == 8) ? $urandom_range(len, len + 3) : $urandom_range(1, 4);
                    for (int k = 0; k < n; k++)
                        send_word(sapc_pkg::OP_PATTERN, 8'(base + $urandom_range(0, 3)),
                                  k == n - 1);
                end
                else
                begin
                    n = ($urandom_range(3) == 0) ? $urandom_range(PAT_MAX, PAT_MAX + 8)
                                                 : $urandom_range(1, 6);
                    for (int k = 0; k < n; k++)
                        send_word(sapc_pkg::OP_PATTERN, 8'($urandom), k == n - 1);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("%0d words in, %0d results: %0d builds, %0d counts (%0d non-zero)",
                 words_in, words_out, builds, counts, hits);
        $display("%0d mismatches", errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
design/sapc_pkg.sv
design/sapc_ram.sv
design/sapc_build.sv
design/sapc_search.sv
design/suffix_array_pattern_count.sv
bench/suffix_array_pattern_count_tb.sv
